// ===== hw/rtl/bandlimited_audio_oscillator_top_defines.svh =====
// Assertion macros for the band-limited audio oscillator.
`ifndef BANDLIMITED_AUDIO_OSCILLATOR_TOP_DEFINES_SVH
`define BANDLIMITED_AUDIO_OSCILLATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define BAO_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define BAO_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/bao_pkg.sv =====
// Shared constants and controller/datapath types of the band-limited audio oscillator.
package bao_pkg;

   localparam int SINE_TABLE_SIZE_DEF = 1024;
   localparam int PHASE_BITS_DEF      = 24;

   localparam int STEP_W   = 23;
   localparam int SAMPLE_W = 16;
   localparam int WAVE_W   = 2;
   localparam int AMP_W    = 16;
   localparam int PW_W     = 24;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [WAVE_W-1:0] WAVE_SAW   = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_PULSE = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_SINE  = 2'd2;
   // The remaining code is unused and gives a silent output.
   localparam logic [WAVE_W-1:0] WAVE_NONE  = 2'd3;

   localparam logic [1:0] REG_WAVEFORM    = 2'd0;
   localparam logic [1:0] REG_AMPLITUDE   = 2'd1;
   localparam logic [1:0] REG_PULSE_WIDTH = 2'd2;

   localparam logic [WAVE_W-1:0] WAVEFORM_RESET    = WAVE_SAW;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RESET   = 16'd32768;
   localparam logic [PW_W-1:0]   PULSE_WIDTH_RESET = 24'd8388608;

   typedef struct packed {
      logic load;
      logic blep_setup;
      logic div_step;
      logic square;
      logic accum;
      logic second;
      logic sine_pos;
      logic rd_a;
      logic rd_b;
      logic mul0;
      logic mul1;
      logic sine_val;
      logic scale;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_saw;
      logic is_pulse;
      logic is_sine;
      logic region_hit;
      logic div_last;
      logic more;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/bao_if.sv =====
// Item channel interfaces: sample ticks in, oscillator samples out.
interface bao_req_if;
   logic                          valid;
   logic                          ready;
   logic [bao_pkg::STEP_W-1:0]    phase_step;
   modport source (output valid, output phase_step, input ready);
   modport sink   (input valid, input phase_step, output ready);
endinterface

interface bao_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bao_pkg::SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/bao_ctrl.sv =====
// Sequencing state machine of the oscillator.
module bao_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bao_pkg::status_type status,
   output bao_pkg::cmd_type    cmd
);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_BCHK  = 14'b00000000000010,
      ST_DIV   = 14'b00000000000100,
      ST_SQR   = 14'b00000000001000,
      ST_ACC   = 14'b00000000010000,
      ST_NEXT  = 14'b00000000100000,
      ST_SPOS  = 14'b00000001000000,
      ST_SRDA  = 14'b00000010000000,
      ST_SRDB  = 14'b00000100000000,
      ST_SM0   = 14'b00001000000000,
      ST_SM1   = 14'b00010000000000,
      ST_SVAL  = 14'b00100000000000,
      ST_SCALE = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.is_saw || status.is_pulse) begin
                  state_in = ST_BCHK;
               end else if (status.is_sine) begin
                  state_in = ST_SPOS;
               end else begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_BCHK: begin
            cmd.blep_setup = 1'b1;
            state_in = status.region_hit ? ST_DIV : ST_NEXT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            cmd.square = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.accum = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (status.more) begin
               cmd.second = 1'b1;
               state_in = ST_BCHK;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SPOS: begin
            cmd.sine_pos = 1'b1;
            state_in = ST_SRDA;
         end
         ST_SRDA: begin
            cmd.rd_a = 1'b1;
            state_in = ST_SRDB;
         end
         ST_SRDB: begin
            cmd.rd_b = 1'b1;
            state_in = ST_SM0;
         end
         ST_SM0: begin
            cmd.mul0 = 1'b1;
            state_in = ST_SM1;
         end
         ST_SM1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_SVAL;
         end
         ST_SVAL: begin
            cmd.sine_val = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/bao_datapath.sv =====
// Phase accumulator, polyBLEP divider, sine ROM interpolation and output scaling.
module bao_datapath #(
   parameter int SINE_TABLE_SIZE = bao_pkg::SINE_TABLE_SIZE_DEF,
   parameter int PHASE_BITS      = bao_pkg::PHASE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bao_pkg::cmd_type                    cmd,
   output bao_pkg::status_type                 status,
   input  logic [bao_pkg::STEP_W-1:0]          phase_step,
   input  logic [bao_pkg::WAVE_W-1:0]          waveform,
   input  logic [bao_pkg::AMP_W-1:0]           amplitude,
   input  logic [bao_pkg::PW_W-1:0]            pulse_width,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [bao_pkg::SAMPLE_W-1:0] sample
);

   localparam int P      = PHASE_BITS;
   localparam int ACC_W  = P + 3;
   localparam int IDX_W  = $clog2(SINE_TABLE_SIZE);
   localparam int POS_W  = P + IDX_W;
   localparam int SUM_W  = P + 17;
   localparam int PROD_W = ACC_W + 17;
   localparam int CNT_W  = $clog2(P);
   localparam int SH_W   = P + 24;
   localparam int UP     = (P >= 24) ? P - 24 : 0;
   localparam int DN     = (P < 24) ? 24 - P : 0;
   localparam logic [P:0] PONE_W = {1'b1, {P{1'b0}}};
   localparam logic signed [ACC_W-1:0] PONE_A = ACC_W'(PONE_W);

   typedef logic signed [15:0] rom_type [SINE_TABLE_SIZE];

   // One sine period: quadrant folding, then a Horner Taylor series to x^11 in Q30.
   function automatic rom_type build_rom();
      rom_type    r;
      logic [63:0] u, q, rr, x, x2, t, s;
      integer     k;
      for (k = 0; k < SINE_TABLE_SIZE; k++) begin
         u  = (64'(k) << 32) / 64'(SINE_TABLE_SIZE);
         q  = (u >> 30) & 64'd3;
         rr = u & 64'h3FFF_FFFF;
         if (q[0]) begin
            rr = 64'h4000_0000 - rr;
         end
         x  = (rr * 64'd1686629713) >> 30;
         x2 = (x * x) >> 30;
         t  = 64'h4000_0000;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd110;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd72;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd42;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd20;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         s  = (s + 64'd16384) >> 15;
         if (s > 64'd32767) begin
            s = 64'd32767;
         end
         r[k] = (q >= 64'd2) ? 16'(64'd0 - s) : 16'(s);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [P-1:0]              phase_ff, t_ff, x_ff, dt_ff, pw_ff, rem_ff, q_ff, sq_ff;
   logic [P-1:0]              frac_ff;
   logic [IDX_W-1:0]          idx_ff, nxt_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      hi_ff, second_ff, valid_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [15:0]        a_ff, b_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [15:0]        sample_ff;

   logic [SH_W-1:0]           dt_sh, pw_sh;
   logic [P-1:0]              dt_p, pw_p;
   logic signed [ACC_W-1:0]   base, blep, two_u, sq_v;
   logic                      lo, hi, sub;
   logic [P:0]                shifted, wgt;
   logic [POS_W-1:0]          pos;
   logic [2*P-1:0]            sq_full;
   logic signed [PROD_W-1:0]  rnd, qv;
   logic signed [15:0]        sat;

   assign dt_sh = (SH_W'(phase_step) << UP) >> DN;
   assign pw_sh = (SH_W'(pulse_width) << UP) >> DN;
   assign dt_p  = dt_sh[P-1:0];
   assign pw_p  = pw_sh[P-1:0];

   always_comb begin
      case (waveform)
         bao_pkg::WAVE_SAW:   base = $signed({2'b00, phase_ff, 1'b0}) - PONE_A;
         bao_pkg::WAVE_PULSE: base = (phase_ff >= pw_p) ? -PONE_A : PONE_A;
         default:             base = '0;
      endcase
   end

   // Region tests; a zero step hits neither, so the correction drops out.
   assign lo = (x_ff < dt_ff);
   assign hi = (({1'b0, x_ff} + {1'b0, dt_ff}) > PONE_W);

   assign shifted = {rem_ff, 1'b0};
   assign sq_full = (2*P)'(q_ff) * (2*P)'(q_ff);
   assign two_u   = $signed({2'b00, q_ff, 1'b0});
   assign sq_v    = $signed({3'b000, sq_ff});
   assign blep    = hi_ff ? (sq_v - two_u + PONE_A) : (two_u - sq_v - PONE_A);
   assign sub     = (waveform == bao_pkg::WAVE_SAW) || second_ff;
   assign pos     = POS_W'(t_ff) * POS_W'(SINE_TABLE_SIZE);
   assign wgt     = PONE_W - {1'b0, frac_ff};

   assign rnd = prod_ff + (PROD_W'(1) << (P - 1));
   assign qv  = rnd >>> P;
   always_comb begin
      if (qv > PROD_W'(32767)) begin
         sat = 16'sd32767;
      end else if (qv < -PROD_W'(32768)) begin
         sat = -16'sd32768;
      end else begin
         sat = qv[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         cnt_ff    <= '0;
         second_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            second_ff <= 1'b0;
         end else if (cmd.second) begin
            second_ff <= 1'b1;
         end
         if (cmd.blep_setup) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            phase_ff <= t_ff + dt_ff;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dt_ff  <= dt_p;
         pw_ff  <= pw_p;
         t_ff   <= phase_ff;
         x_ff   <= phase_ff;
         acc_ff <= base;
      end
      if (cmd.second) begin
         x_ff <= t_ff - pw_ff;
      end
      if (cmd.blep_setup) begin
         rem_ff <= lo ? x_ff : P'(PONE_W - {1'b0, x_ff});
         hi_ff  <= !lo;
      end
      // Restoring division, one quotient bit per cycle.
      if (cmd.div_step) begin
         if (shifted >= {1'b0, dt_ff}) begin
            rem_ff <= P'(shifted - {1'b0, dt_ff});
            q_ff   <= {q_ff[P-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[P-1:0];
            q_ff   <= {q_ff[P-2:0], 1'b0};
         end
      end
      if (cmd.square) begin
         sq_ff <= sq_full[2*P-1:P];
      end
      if (cmd.accum) begin
         acc_ff <= sub ? (acc_ff - blep) : (acc_ff + blep);
      end
      if (cmd.sine_pos) begin
         idx_ff  <= pos[POS_W-1:P];
         frac_ff <= pos[P-1:0];
         nxt_ff  <= (pos[POS_W-1:P] == IDX_W'(SINE_TABLE_SIZE - 1)) ? '0
                    : pos[POS_W-1:P] + IDX_W'(1);
      end
      if (cmd.rd_a) begin
         a_ff <= SINE_ROM[idx_ff];
      end
      if (cmd.rd_b) begin
         b_ff <= SINE_ROM[nxt_ff];
      end
      if (cmd.mul0) begin
         sum_ff <= SUM_W'({~a_ff[15], a_ff[14:0]}) * SUM_W'(wgt);
      end
      if (cmd.mul1) begin
         sum_ff <= sum_ff + SUM_W'({~b_ff[15], b_ff[14:0]}) * SUM_W'(frac_ff);
      end
      if (cmd.sine_val) begin
         acc_ff <= $signed({1'b0, sum_ff[SUM_W-1:15]}) - PONE_A;
      end
      if (cmd.scale) begin
         prod_ff <= PROD_W'(acc_ff) * PROD_W'($signed({1'b0, amplitude}));
      end
      if (cmd.out_load) begin
         sample_ff <= sat;
      end
   end

   assign status.is_saw     = (waveform == bao_pkg::WAVE_SAW);
   assign status.is_pulse   = (waveform == bao_pkg::WAVE_PULSE);
   assign status.is_sine    = (waveform == bao_pkg::WAVE_SINE);
   assign status.region_hit = lo || hi;
   assign status.div_last   = (cnt_ff == CNT_W'(P - 1));
   assign status.more       = (waveform == bao_pkg::WAVE_PULSE) && !second_ff;
   assign status.out_free   = !valid_ff || rsp_ready;

   assign rsp_valid = valid_ff;
   assign sample    = sample_ff;

endmodule

// ===== hw/rtl/bandlimited_audio_oscillator_top.sv =====
// Top level of the band-limited audio oscillator: register file, controller and datapath.
//
//   channel   direction  payload                 handshake
//   req_ch    in         phase_step [22:0]       valid/ready
//   rsp_ch    out        sample [15:0] signed    valid/ready
//   csr_*     in/out     3 registers, 32 bits    APB write and read
//
// One item at a time. A sine item finds its table position, reads two entries, blends them
// in two multiplies and scales; an item with the unused waveform code is only scaled. A
// sawtooth runs the divider and correction only when its phase lies in a correction region;
// a pulse runs two correction checks. The restoring divider of the correction gives one
// quotient bit a cycle, and the next item is taken only once the controller is back in
// idle after the result register is loaded. Synchronous reset clears the phase and the
// output valid, resets the controller to idle and the registers to their reset values;
// a result waiting on a stalled output holds the block until taken.
`include "bandlimited_audio_oscillator_top_defines.svh"
module bandlimited_audio_oscillator_top #(
   parameter int SINE_TABLE_SIZE = bao_pkg::SINE_TABLE_SIZE_DEF,
   parameter int PHASE_BITS      = bao_pkg::PHASE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bao_req_if.sink                        req_ch,
   bao_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bao_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [bao_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [bao_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);

   logic [bao_pkg::WAVE_W-1:0] waveform_ff;
   logic [bao_pkg::AMP_W-1:0]  amplitude_ff;
   logic [bao_pkg::PW_W-1:0]   pulse_width_ff;
   logic                       wr_en;
   logic                       req_take;

   bao_pkg::cmd_type    cmd;
   bao_pkg::status_type status;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign req_take   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff    <= bao_pkg::WAVEFORM_RESET;
         amplitude_ff   <= bao_pkg::AMPLITUDE_RESET;
         pulse_width_ff <= bao_pkg::PULSE_WIDTH_RESET;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            bao_pkg::REG_WAVEFORM:    waveform_ff    <= csr_pwdata[bao_pkg::WAVE_W-1:0];
            bao_pkg::REG_AMPLITUDE:   amplitude_ff   <= csr_pwdata[bao_pkg::AMP_W-1:0];
            bao_pkg::REG_PULSE_WIDTH: pulse_width_ff <= csr_pwdata[bao_pkg::PW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         bao_pkg::REG_WAVEFORM:    csr_prdata = bao_pkg::CSR_DW'(waveform_ff);
         bao_pkg::REG_AMPLITUDE:   csr_prdata = bao_pkg::CSR_DW'(amplitude_ff);
         bao_pkg::REG_PULSE_WIDTH: csr_prdata = bao_pkg::CSR_DW'(pulse_width_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   bao_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bao_datapath #(
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
      .PHASE_BITS      (PHASE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .phase_step  (req_ch.phase_step),
      .waveform    (waveform_ff),
      .amplitude   (amplitude_ff),
      .pulse_width (pulse_width_ff),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .sample      (rsp_ch.sample)
   );

   // The block is not ready in the cycle after taking an item.
   `BAO_ASSERT_NEXT(a_busy_after_accept, req_take, !req_ch.ready, "item accepted back to back")
   // A new result is written only into a free output register.
   `BAO_ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !rsp_ch.valid || rsp_ch.ready, "overwrite")
   // An item is only loaded when the block is ready for it.
   `BAO_ASSERT_IMPLIES(a_load_ready, cmd.load, req_take, "load without accept")

endmodule
